>>> src/yq2r_pkg.sv
// shared types and constants for the ycbcr 4:2:0 quad to rgb converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package yq2r_pkg;

	// configuration register indexes
	localparam logic CFG_OUTPUT_FORMAT = 1'b0;
	localparam logic CFG_HALF_SIZE     = 1'b1;

	// output format codes; bit 1 set selects the 16-bit packing
	localparam logic [1:0] FMT_RGB24  = 2'd0;
	localparam logic [1:0] FMT_BGR24  = 2'd1;
	localparam logic [1:0] FMT_RGB565 = 2'd2;

	// chroma coefficients and rounding term
	localparam logic signed [17:0] K_RV  = 18'sd409;
	localparam logic signed [17:0] K_GU  = -18'sd100;
	localparam logic signed [17:0] K_GV  = -18'sd208;
	localparam logic signed [17:0] K_BU  = 18'sd516;
	localparam logic signed [17:0] K_RND = 18'sd128;

	// luma scale and black level
	localparam logic [16:0] K_Y   = 17'd298;
	localparam logic [7:0]  Y_OFS = 8'd16;

	// one pixel handed from the quad stage to the output stage
	typedef struct packed {
		logic                valid;
		logic [7:0]          luma;
		logic [1:0]          slot;
		logic                last;
		logic signed [17:0]  r_term;
		logic signed [17:0]  g_term;
		logic signed [17:0]  b_term;
	} pix_req_t;

endpackage

`default_nettype wire

>>> src/yq2r_if.sv
// valid/ready channels for quads in and packed pixels out
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface yq2r_quad_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma_top_left;
	logic [7:0] luma_top_right;
	logic [7:0] luma_bottom_left;
	logic [7:0] luma_bottom_right;
	logic [7:0] cb_sample;
	logic [7:0] cr_sample;
	logic [3:0] pixel_mask;

	modport source (
		output valid, luma_top_left, luma_top_right, luma_bottom_left,
		       luma_bottom_right, cb_sample, cr_sample, pixel_mask,
		input  ready
	);
	modport sink (
		input  valid, luma_top_left, luma_top_right, luma_bottom_left,
		       luma_bottom_right, cb_sample, cr_sample, pixel_mask,
		output ready
	);
endinterface

interface yq2r_pixel_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel_word;
	logic [1:0]  pixel_slot;
	logic        last_pixel;

	modport source (
		output valid, pixel_word, pixel_slot, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_word, pixel_slot, last_pixel,
		output ready
	);
endinterface

`default_nettype wire

>>> src/yq2r_quad_stage.sv
// input register for one quad: chroma terms, half-size luma average and
// the list of pixels still to emit; uses yq2r_pkg and yq2r_quad_if
`timescale 1ns / 1ps
`default_nettype none

module yq2r_quad_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	yq2r_quad_if.sink          quad_in,
	input  wire logic          half_size,
	input  wire logic          adv,
	output yq2r_pkg::pix_req_t req
);

	logic [3:0]         pend_s1;
	logic [7:0]         luma_s1 [4];
	logic signed [17:0] r_term_s1;
	logic signed [17:0] g_term_s1;
	logic signed [17:0] b_term_s1;

	logic [3:0]         cur;
	logic [3:0]         rest;
	logic [1:0]         slot;
	logic               accept;
	logic [9:0]         luma_sum;
	logic [3:0]         load_mask;
	logic signed [17:0] d_x;
	logic signed [17:0] e_x;

	// lowest pending pixel goes next
	assign cur  = pend_s1 & (~pend_s1 + 4'd1);
	assign rest = pend_s1 & ~cur;

	always_comb begin
		unique case (1'b1)
			cur[1]:  slot = 2'd1;
			cur[2]:  slot = 2'd2;
			cur[3]:  slot = 2'd3;
			default: slot = 2'd0;
		endcase
	end

	assign quad_in.ready = (pend_s1 == 4'd0) || (adv && (rest == 4'd0));
	assign accept        = quad_in.valid && quad_in.ready;

	assign luma_sum = 10'(quad_in.luma_top_left) + 10'(quad_in.luma_top_right)
		+ 10'(quad_in.luma_bottom_left) + 10'(quad_in.luma_bottom_right) + 10'd2;

	// half mode always yields exactly one pixel in slot 0
	assign load_mask = half_size ? 4'b0001 : quad_in.pixel_mask;

	// flipping the top bit turns an offset-128 byte into a signed one
	assign d_x = 18'(signed'(quad_in.cb_sample ^ 8'h80));
	assign e_x = 18'(signed'(quad_in.cr_sample ^ 8'h80));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 4'd0;
		end else if (accept) begin
			pend_s1 <= load_mask;
		end else if (adv) begin
			pend_s1 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1[0] <= half_size ? luma_sum[9:2] : quad_in.luma_top_left;
			luma_s1[1] <= quad_in.luma_top_right;
			luma_s1[2] <= quad_in.luma_bottom_left;
			luma_s1[3] <= quad_in.luma_bottom_right;
			r_term_s1  <= 18'(e_x * yq2r_pkg::K_RV) + yq2r_pkg::K_RND;
			g_term_s1  <= 18'(d_x * yq2r_pkg::K_GU) + 18'(e_x * yq2r_pkg::K_GV)
				+ yq2r_pkg::K_RND;
			b_term_s1  <= 18'(d_x * yq2r_pkg::K_BU) + yq2r_pkg::K_RND;
		end
	end

	always_comb begin
		req.valid  = (pend_s1 != 4'd0);
		req.luma   = luma_s1[slot];
		req.slot   = slot;
		req.last   = (rest == 4'd0);
		req.r_term = r_term_s1;
		req.g_term = g_term_s1;
		req.b_term = b_term_s1;
	end

endmodule

`default_nettype wire

>>> src/yq2r_pixel_conv.sv
// luma scaling, channel clipping, format packing and the result register
// uses yq2r_pkg and yq2r_pixel_if
`timescale 1ns / 1ps
`default_nettype none

module yq2r_pixel_conv (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire yq2r_pkg::pix_req_t req,
	input  wire logic [1:0]         output_format,
	output logic                    adv,
	yq2r_pixel_if.source            pixel_out
);

	logic        valid_q;
	logic [23:0] word_q;
	logic [1:0]  slot_q;
	logic        last_q;

	logic        space;
	logic [7:0]  y_ofs;
	logic [16:0] y_scaled;
	logic [7:0]  r;
	logic [7:0]  g;
	logic [7:0]  b;
	logic [23:0] word;

	// floor shift then clip to 0..255
	function automatic logic [7:0] clip(input logic signed [19:0] sum);
		logic signed [19:0] sh;
		sh = sum >>> 8;
		if (sh[19]) begin
			return 8'd0;
		end else if (sh[18:8] != 11'd0) begin
			return 8'hFF;
		end
		return sh[7:0];
	endfunction

	assign y_ofs    = (req.luma < yq2r_pkg::Y_OFS) ? 8'd0 : req.luma - yq2r_pkg::Y_OFS;
	assign y_scaled = 17'(y_ofs) * yq2r_pkg::K_Y;

	assign r = clip(signed'({3'b000, y_scaled}) + 20'(req.r_term));
	assign g = clip(signed'({3'b000, y_scaled}) + 20'(req.g_term));
	assign b = clip(signed'({3'b000, y_scaled}) + 20'(req.b_term));

	always_comb begin
		if (output_format == yq2r_pkg::FMT_RGB24) begin
			word = {b, g, r};
		end else if (output_format == yq2r_pkg::FMT_BGR24) begin
			word = {r, g, b};
		end else begin
			word = {8'd0, r[7:3], g[7:2], b[7:3]};
		end
	end

	assign space = !valid_q || pixel_out.ready;
	assign adv   = req.valid && space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= word;
			slot_q <= req.slot;
			last_q <= req.last;
		end
	end

	assign pixel_out.valid      = valid_q;
	assign pixel_out.pixel_word = word_q;
	assign pixel_out.pixel_slot = slot_q;
	assign pixel_out.last_pixel = last_q;

endmodule

`default_nettype wire

>>> src/ycbcr420_quad_to_rgb_unit.sv
// top level of the ycbcr 4:2:0 quad to rgb converter
// uses yq2r_pkg, yq2r_if, yq2r_quad_stage and yq2r_pixel_conv
`timescale 1ns / 1ps
`default_nettype none

// Converts 4:2:0 quads (four luma bytes, one Cb, one Cr) to packed RGB24,
// BGR24 or RGB565 pixels with the BT.601 limited-range integer formula.
// A quad is registered on entry, then one pixel per cycle, unless the
// output stalls, goes through a single conversion datapath into the output
// register, so a full-mode quad holds the block until its present pixels
// (1 to 4) are all through; a quad with an empty mask is taken and gives
// nothing, and half-mode quads go at one per cycle unless stalled. The next
// quad is taken in the cycle its predecessor's last pixel moves to the output
// register. Pixels come in TL, TR, BL, BR order, last_pixel marks the final
// one of a quad. Write output_format and half_size only while idle.
module ycbcr420_quad_to_rgb_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	yq2r_quad_if.sink       quad_in,
	yq2r_pixel_if.source    pixel_out,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [1:0] cfg_wdata
);

	logic [1:0]         output_format_q;
	logic               half_size_q;
	logic               adv;
	yq2r_pkg::pix_req_t req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_format_q <= yq2r_pkg::FMT_RGB24;
			half_size_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				yq2r_pkg::CFG_OUTPUT_FORMAT: output_format_q <= cfg_wdata;
				yq2r_pkg::CFG_HALF_SIZE:     half_size_q     <= cfg_wdata[0];
			endcase
		end
	end

	yq2r_quad_stage u_quad (
		.clk       (clk),
		.arst_n    (arst_n),
		.quad_in   (quad_in),
		.half_size (half_size_q),
		.adv       (adv),
		.req       (req)
	);

	yq2r_pixel_conv u_conv (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.output_format (output_format_q),
		.adv           (adv),
		.pixel_out     (pixel_out)
	);

endmodule

`default_nettype wire

>>> src/yq2r_checker.sv
// port-level checks for ycbcr420_quad_to_rgb_unit and the bind that attaches them
// depends on the top level's clock, reset and pixel channel ports only
`timescale 1ns / 1ps
`default_nettype none

module yq2r_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [23:0] pixel_word,
	input wire logic [1:0]  pixel_slot,
	input wire logic        last_pixel
);

	// nothing leaves while held in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("pixel word shown during reset");

	// a stalled word stays put
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_word)
		&& $stable(pixel_slot) && $stable(last_pixel))
		else $error("stalled pixel word changed");

	// the rest of a quad follows at once, further along in the quad
	a_quad_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_pixel |=> out_valid)
		else $error("gap inside a quad");

	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_pixel |=> pixel_slot > $past(pixel_slot))
		else $error("quad pixels out of order");

endmodule

bind ycbcr420_quad_to_rgb_unit yq2r_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (pixel_out.valid),
	.out_ready  (pixel_out.ready),
	.pixel_word (pixel_out.pixel_word),
	.pixel_slot (pixel_out.pixel_slot),
	.last_pixel (pixel_out.last_pixel)
);

`default_nettype wire
